@@ rtl/core/phed_pkg.sv @@
`timescale 1ns / 1ps
// Package with constants, types and helper functions of the prefixed hex escape decoder.
package phed_pkg;

	localparam int MAX_PREFIX_LEN_DEF = 4;
	localparam int NUM_DECODERS_DEF   = 3;
	localparam int HEX_DIGITS         = 2;
	localparam int PREFIX_SETS        = 3;
	localparam int PREFIX_BYTES       = 4;
	localparam int VIEW_DEPTH         = 8;
	localparam int LEN_W              = 3;
	localparam int USED_W             = 3;
	localparam int ADDR_W             = 5;
	localparam int DATA_W             = 32;

	typedef enum logic [2:0] {
		REG_DECODER_COUNT = 3'd0,
		REG_FIRST_CHARS   = 3'd1,
		REG_FIRST_LEN     = 3'd2,
		REG_SECOND_CHARS  = 3'd3,
		REG_SECOND_LEN    = 3'd4,
		REG_THIRD_CHARS   = 3'd5,
		REG_THIRD_LEN     = 3'd6,
		REG_NONE          = 3'd7
	} reg_idx_t;

	localparam logic [1:0]        RST_DECODER_COUNT = 2'd3;
	localparam logic [31:0]       RST_FIRST_CHARS   = 32'h0035_3225;
	localparam logic [LEN_W-1:0]  RST_FIRST_LEN     = 3'd3;
	localparam logic [31:0]       RST_SECOND_CHARS  = 32'h3030_7525;
	localparam logic [LEN_W-1:0]  RST_SECOND_LEN    = 3'd4;
	localparam logic [31:0]       RST_THIRD_CHARS   = 32'h0000_0025;
	localparam logic [LEN_W-1:0]  RST_THIRD_LEN     = 3'd1;

	typedef struct packed {
		logic [1:0]                         decoder_count;
		logic [PREFIX_SETS-1:0][31:0]       chars;
		logic [PREFIX_SETS-1:0][LEN_W-1:0]  len;
	} cfg_t;

	typedef struct packed {
		logic append;
		logic decide;
	} ctrl_cmd_t;

	typedef struct packed {
		logic need_decide;
		logic out_space;
		logic more_after;
	} dp_stat_t;

	function automatic logic hex_valid(input logic [7:0] c);
		return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66) ||
			(c >= 8'h41 && c <= 8'h46);
	endfunction

	function automatic logic [3:0] hex_value(input logic [7:0] c);
		return (c <= 8'h39) ? c[3:0] : c[3:0] + 4'd9;
	endfunction

endpackage

@@ rtl/core/phed_in_if.sv @@
`timescale 1ns / 1ps
// Input byte channel with valid/ready handshake.
interface phed_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       in_last;

	modport source (output valid, output in_byte, output in_last, input ready);
	modport sink (input valid, input in_byte, input in_last, output ready);
endinterface

@@ rtl/core/phed_out_if.sv @@
`timescale 1ns / 1ps
// Output byte channel with valid/ready handshake.
interface phed_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       out_last;

	modport source (output valid, output out_byte, output out_last, input ready);
	modport sink (input valid, input out_byte, input out_last, output ready);
endinterface

@@ rtl/core/phed_regs.sv @@
`timescale 1ns / 1ps
// APB-style configuration register file of the decoder.
module phed_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [phed_pkg::ADDR_W-1:0]   paddr,
	input  logic [phed_pkg::DATA_W-1:0]   pwdata,
	output logic [phed_pkg::DATA_W-1:0]   prdata,
	output logic                          pready,
	output phed_pkg::cfg_t                cfg
);

	phed_pkg::cfg_t    cfg_q;
	phed_pkg::reg_idx_t idx;
	logic              wr_en;

	assign pready = 1'b1;
	assign idx    = phed_pkg::reg_idx_t'(paddr[4:2]);
	assign wr_en  = psel && penable && pwrite;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.decoder_count <= phed_pkg::RST_DECODER_COUNT;
			cfg_q.chars[0]      <= phed_pkg::RST_FIRST_CHARS;
			cfg_q.len[0]        <= phed_pkg::RST_FIRST_LEN;
			cfg_q.chars[1]      <= phed_pkg::RST_SECOND_CHARS;
			cfg_q.len[1]        <= phed_pkg::RST_SECOND_LEN;
			cfg_q.chars[2]      <= phed_pkg::RST_THIRD_CHARS;
			cfg_q.len[2]        <= phed_pkg::RST_THIRD_LEN;
		end else if (wr_en) begin
			unique case (idx)
				phed_pkg::REG_DECODER_COUNT: cfg_q.decoder_count <= pwdata[1:0];
				phed_pkg::REG_FIRST_CHARS:   cfg_q.chars[0] <= pwdata;
				phed_pkg::REG_FIRST_LEN:     cfg_q.len[0] <= pwdata[2:0];
				phed_pkg::REG_SECOND_CHARS:  cfg_q.chars[1] <= pwdata;
				phed_pkg::REG_SECOND_LEN:    cfg_q.len[1] <= pwdata[2:0];
				phed_pkg::REG_THIRD_CHARS:   cfg_q.chars[2] <= pwdata;
				phed_pkg::REG_THIRD_LEN:     cfg_q.len[2] <= pwdata[2:0];
				phed_pkg::REG_NONE:          ;
				default:                     ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			phed_pkg::REG_DECODER_COUNT: prdata = {30'd0, cfg_q.decoder_count};
			phed_pkg::REG_FIRST_CHARS:   prdata = cfg_q.chars[0];
			phed_pkg::REG_FIRST_LEN:     prdata = {29'd0, cfg_q.len[0]};
			phed_pkg::REG_SECOND_CHARS:  prdata = cfg_q.chars[1];
			phed_pkg::REG_SECOND_LEN:    prdata = {29'd0, cfg_q.len[1]};
			phed_pkg::REG_THIRD_CHARS:   prdata = cfg_q.chars[2];
			phed_pkg::REG_THIRD_LEN:     prdata = {29'd0, cfg_q.len[2]};
			default:                     prdata = '0;
		endcase
	end

endmodule

@@ rtl/core/phed_ctrl.sv @@
`timescale 1ns / 1ps
// Controller state machine that sequences byte intake and head decisions.
module phed_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  phed_pkg::dp_stat_t    stat,
	output phed_pkg::ctrl_cmd_t   cmd
);

	typedef enum logic {
		ST_IDLE,
		ST_CHECK
	} state_t;

	state_t state_q;

	assign in_ready   = (state_q == ST_IDLE);
	assign cmd.append = (state_q == ST_IDLE) && in_valid;
	assign cmd.decide = (state_q == ST_CHECK) && stat.need_decide && stat.out_space;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					if (!stat.need_decide) begin
						state_q <= ST_IDLE;
					end else if (stat.out_space && !stat.more_after) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

@@ rtl/core/phed_dp.sv @@
`timescale 1ns / 1ps
// Datapath with the lookahead window, prefix matchers and output register.
module phed_dp #(
	parameter int MAX_PREFIX_LEN = phed_pkg::MAX_PREFIX_LEN_DEF,
	parameter int NUM_DECODERS   = phed_pkg::NUM_DECODERS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  phed_pkg::cfg_t        cfg,
	input  phed_pkg::ctrl_cmd_t   cmd,
	output phed_pkg::dp_stat_t    stat,
	input  logic [7:0]            in_byte,
	input  logic                  in_last,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [7:0]            out_byte,
	output logic                  out_last
);

	localparam int WIN       = MAX_PREFIX_LEN + phed_pkg::HEX_DIGITS;
	localparam int FILL_W    = $clog2(WIN + 1);
	localparam int LEN_LIMIT = (MAX_PREFIX_LEN < phed_pkg::PREFIX_BYTES) ?
		MAX_PREFIX_LEN : phed_pkg::PREFIX_BYTES;

	logic [WIN-1:0][7:0]                  window_q;
	logic [FILL_W-1:0]                    fill_q;
	logic                                 last_q;
	logic                                 out_valid_q;
	logic [7:0]                           out_byte_q;
	logic                                 out_last_q;

	logic [phed_pkg::VIEW_DEPTH-1:0][7:0] view;
	logic                                 found;
	logic                                 ok;
	logic [phed_pkg::LEN_W-1:0]           len_k;
	logic [7:0]                           hi_c;
	logic [7:0]                           lo_c;
	logic [7:0]                           dec_byte;
	logic [phed_pkg::USED_W-1:0]          used;
	logic [FILL_W-1:0]                    fill_next;

	for (genvar g = 0; g < phed_pkg::VIEW_DEPTH; g++) begin : g_view
		if (g < WIN) begin : g_win
			assign view[g] = window_q[g];
		end else begin : g_pad
			assign view[g] = 8'd0;
		end
	end

	always_comb begin
		found    = 1'b0;
		ok       = 1'b0;
		len_k    = '0;
		hi_c     = '0;
		lo_c     = '0;
		dec_byte = view[0];
		used     = phed_pkg::USED_W'(1);
		for (int k = 0; k < phed_pkg::PREFIX_SETS; k++) begin
			len_k = cfg.len[k];
			ok = (k < NUM_DECODERS) && (cfg.decoder_count > 2'(k)) &&
				(len_k <= phed_pkg::LEN_W'(LEN_LIMIT)) &&
				(5'(len_k) + 5'(phed_pkg::HEX_DIGITS) <= 5'(fill_q));
			for (int i = 0; i < phed_pkg::PREFIX_BYTES; i++) begin
				if ((phed_pkg::LEN_W'(i) < len_k) && (view[i] != cfg.chars[k][8*i +: 8])) begin
					ok = 1'b0;
				end
			end
			hi_c = view[len_k];
			lo_c = view[len_k + 3'd1];
			ok   = ok && phed_pkg::hex_valid(hi_c) && phed_pkg::hex_valid(lo_c);
			if (ok && !found) begin
				found    = 1'b1;
				dec_byte = {phed_pkg::hex_value(hi_c), phed_pkg::hex_value(lo_c)};
				used     = phed_pkg::USED_W'(len_k) + phed_pkg::USED_W'(phed_pkg::HEX_DIGITS);
			end
		end
	end

	assign fill_next        = fill_q - FILL_W'(used);
	assign stat.need_decide = (fill_q != '0) && ((fill_q == FILL_W'(WIN)) || last_q);
	assign stat.out_space   = !out_valid_q || out_ready;
	assign stat.more_after  = last_q && (fill_next != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= '0;
			fill_q   <= '0;
			last_q   <= 1'b0;
		end else if (cmd.append) begin
			for (int i = 0; i < WIN; i++) begin
				if (fill_q == FILL_W'(i)) begin
					window_q[i] <= in_byte;
				end
			end
			fill_q <= fill_q + FILL_W'(1);
			last_q <= in_last;
		end else if (cmd.decide) begin
			window_q <= window_q >> {used, 3'b000};
			fill_q   <= fill_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.decide) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.decide) begin
			out_byte_q <= dec_byte;
			out_last_q <= last_q && (fill_next == '0);
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign out_last  = out_last_q;

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FILL_W'(WIN))
		else $error("window fill beyond depth");

	a_append_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.append |-> fill_q < FILL_W'(WIN))
		else $error("byte appended to a full window");

	a_decide_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.decide |-> (fill_q != '0) && (FILL_W'(used) <= fill_q))
		else $error("decision consumes more bytes than held");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.decide |-> (!out_valid_q || out_ready))
		else $error("pending output item overwritten");

	a_drained_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.decide && last_q && (fill_next == '0)) |=> (fill_q == '0) && out_last)
		else $error("last item does not leave the window empty");

endmodule

@@ rtl/core/prefixed_hex_escape_decoder.sv @@
`timescale 1ns / 1ps
// Top level of the prefixed hex escape decoder.
// The block takes the bytes of a string on in_ch, the final byte marked by in_last,
// and returns decoded bytes on out_ch, the final one marked by out_last. Up to three
// prefixes, set over the APB port, are tried in order at the head of a lookahead
// window of MAX_PREFIX_LEN + 2 bytes; a matching prefix followed by two hex digits
// becomes one byte, any other head byte passes through unchanged.
// An input item enters the window; a head decision, made by a single match unit
// over the window, follows when the window is full or holds in_last, and gives
// one item; later bytes refill the window. The item that carries in_last drains the
// window at one output item per cycle while out_ch is ready. The output register
// lets the next input item be taken while a result still waits; a stalled receiver
// holds further decisions, and with them further input items. Reset empties the
// window, clears out_valid and loads the default prefixes "%25", "%u00" and "%"
// with all three in use. Configuration is written only while the block is idle;
// the user ensures this, and the block itself does not enforce it.
module prefixed_hex_escape_decoder #(
	parameter int MAX_PREFIX_LEN = phed_pkg::MAX_PREFIX_LEN_DEF,
	parameter int NUM_DECODERS   = phed_pkg::NUM_DECODERS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	phed_in_if.sink                      in_ch,
	phed_out_if.source                   out_ch,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [phed_pkg::ADDR_W-1:0]  paddr,
	input  logic [phed_pkg::DATA_W-1:0]  pwdata,
	output logic [phed_pkg::DATA_W-1:0]  prdata,
	output logic                         pready
);

	phed_pkg::cfg_t      cfg;
	phed_pkg::ctrl_cmd_t cmd;
	phed_pkg::dp_stat_t  stat;

	phed_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	phed_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_ready (in_ch.ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	phed_dp #(
		.MAX_PREFIX_LEN (MAX_PREFIX_LEN),
		.NUM_DECODERS   (NUM_DECODERS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.cmd       (cmd),
		.stat      (stat),
		.in_byte   (in_ch.in_byte),
		.in_last   (in_ch.in_last),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.out_byte  (out_ch.out_byte),
		.out_last  (out_ch.out_last)
	);

endmodule
